// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the score-ordered group list.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SOGL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SOGL_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SOGL_ASSERT(name, clk, rst_n, prop, msg)
`define SOGL_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// File: design/sogl_pkg.sv
// ----------------------------------------------------------------------------
// Score-ordered group list package
// Field widths, status and action codes, and the ring control bundle.
// ----------------------------------------------------------------------------
package sogl_pkg;

    localparam int ID_W        = 4;
    localparam int SCORE_W     = 10;
    localparam int REQ_SCORE_W = 16;
    localparam int STATUS_W    = 2;

    localparam logic [REQ_SCORE_W-1:0] SCORE_MAX = 16'd1000;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAME   = 2'd2;

    typedef struct packed {
        logic shift;
        logic rebuild;
        logic start;
        logic tail_step;
    } ring_ctrl_t;

endpackage

// File: design/sogl_if.sv
// ----------------------------------------------------------------------------
// Score-ordered group list channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sogl_req_if
    import sogl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [ID_W-1:0]        group_id;
    logic [REQ_SCORE_W-1:0] new_score;

    modport source (output valid, output action, output group_id, output new_score,
                    input ready);
    modport sink   (input valid, input action, input group_id, input new_score,
                    output ready);
endinterface

interface sogl_rsp_if
    import sogl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_group;
    logic [SCORE_W-1:0]  out_score;
    logic                last;

    modport source (output valid, output status, output out_group, output out_score,
                    output last, input ready);
    modport sink   (input valid, input status, input out_group, input out_score,
                    input last, output ready);
endinterface

// File: design/sogl_ring.sv
// ----------------------------------------------------------------------------
// Rank ring
// Rotating list of (group, score) pairs, head first, rebuilt one rank a cycle.
// ----------------------------------------------------------------------------
module sogl_ring
    import sogl_pkg::*;
#(
    parameter int GROUPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ring_ctrl_t               ctrl,
    input  logic [$clog2(GROUPS)-1:0] move_id,
    input  logic [SCORE_W-1:0]       move_score,
    output logic [$clog2(GROUPS)-1:0] head_id,
    output logic [SCORE_W-1:0]       head_score
);

    localparam int IdW = $clog2(GROUPS);

    logic [IdW-1:0]     ring_id_reg    [GROUPS];
    logic [SCORE_W-1:0] ring_score_reg [GROUPS];
    logic [IdW-1:0]     prev_id_reg;
    logic [SCORE_W-1:0] prev_score_reg;
    logic               gone_reg;
    logic               gone_next;
    logic               ins_reg;
    logic               ins_next;
    logic               here;
    logic [IdW-1:0]     cand_id;
    logic [SCORE_W-1:0] cand_score;
    logic [IdW-1:0]     tail_id;
    logic [SCORE_W-1:0] tail_score;

    assign head_id    = ring_id_reg[0];
    assign head_score = ring_score_reg[0];
    assign here       = (ring_id_reg[0] == move_id);

    always_comb
    begin
        cand_id    = (gone_reg || here) ? ring_id_reg[1]    : ring_id_reg[0];
        cand_score = (gone_reg || here) ? ring_score_reg[1] : ring_score_reg[0];
        gone_next  = gone_reg || here;
        ins_next   = ins_reg;
        tail_id    = ring_id_reg[0];
        tail_score = ring_score_reg[0];
        if (ctrl.rebuild)
        begin
            if (!ins_reg)
            begin
                if (ctrl.tail_step || (cand_score < move_score))
                begin
                    tail_id    = move_id;
                    tail_score = move_score;
                    ins_next   = 1'b1;
                end
                else
                begin
                    tail_id    = cand_id;
                    tail_score = cand_score;
                end
            end
            else if (!gone_reg)
            begin
                tail_id    = prev_id_reg;
                tail_score = prev_score_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GROUPS; r++)
            begin
                ring_id_reg[r]    <= IdW'(r);
                ring_score_reg[r] <= '0;
            end
            gone_reg <= 1'b0;
            ins_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                gone_reg <= 1'b0;
                ins_reg  <= 1'b0;
            end
            else if (ctrl.shift && ctrl.rebuild)
            begin
                gone_reg <= gone_next;
                ins_reg  <= ins_next;
            end
            if (ctrl.shift)
            begin
                for (int r = 0; r < GROUPS - 1; r++)
                begin
                    ring_id_reg[r]    <= ring_id_reg[r+1];
                    ring_score_reg[r] <= ring_score_reg[r+1];
                end
                ring_id_reg[GROUPS-1]    <= tail_id;
                ring_score_reg[GROUPS-1] <= tail_score;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift && ctrl.rebuild)
        begin
            prev_id_reg    <= ring_id_reg[0];
            prev_score_reg <= ring_score_reg[0];
        end
    end

endmodule

// File: design/score_ordered_group_list.sv
// ----------------------------------------------------------------------------
// Score-ordered group list
// Keeps all groups ranked by score, highest first; sets scores and walks.
//
// Channel   Role    Beat
// req       sink    action, group_id, new_score
// rsp       source  status, out_group, out_score, last
//
// A walk is accepted, then gives GROUPS beats, one beat a cycle unless the
// response stalls. A set-score that changes the score runs LOOKUP, DECIDE,
// REBUILD and REPLY, else it replies from DECIDE: one rank ring rotation
// finds the stored score, a second rebuilds the order, one rank per cycle.
// Reset lists groups in ascending id order with score zero.
// A stalled response holds the sequencer; a new request is taken while the
// final beat still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module score_ordered_group_list
    import sogl_pkg::*;
#(
    parameter int GROUPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    sogl_req_if.sink    req,
    sogl_rsp_if.source  rsp
);

    localparam int IdW = $clog2(GROUPS);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_LOOKUP  = 6'b000010,
        ST_DECIDE  = 6'b000100,
        ST_REBUILD = 6'b001000,
        ST_REPLY   = 6'b010000,
        ST_WALK    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IdW-1:0]         cnt_reg, cnt_next;
    logic [ID_W-1:0]        gid_reg, gid_next;
    logic [REQ_SCORE_W-1:0] req_score_reg, req_score_next;
    logic [SCORE_W-1:0]     old_score_reg, old_score_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [ID_W-1:0]        out_group_reg, out_group_next;
    logic [SCORE_W-1:0]     out_score_reg, out_score_next;
    logic                   out_last_reg, out_last_next;

    ring_ctrl_t             ring_ctrl;
    logic [IdW-1:0]         head_id;
    logic [SCORE_W-1:0]     head_score;
    logic                   emit_ok;
    logic                   emit;
    logic                   cnt_end;
    logic                   gid_ok;
    logic                   req_fire;
    logic                   walk_done;
    logic                   status_bad;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_group = out_group_reg;
    assign rsp.out_score = out_score_reg;
    assign rsp.last      = out_last_reg;

    assign emit_ok = !out_valid_reg || rsp.ready;
    assign cnt_end = (cnt_reg == IdW'(GROUPS - 1));
    assign gid_ok  = ({28'd0, gid_reg} < 32'(GROUPS));

    assign req_fire   = req.valid && req.ready;
    assign walk_done  = (state_reg == ST_WALK) && emit && cnt_end;
    assign status_bad = (out_status_reg != ST_OK) && (out_status_reg != ST_REJECT) &&
                        (out_status_reg != ST_SAME);

    sogl_ring #(
        .GROUPS (GROUPS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ring_ctrl),
        .move_id    (IdW'(gid_reg)),
        .move_score (SCORE_W'(req_score_reg)),
        .head_id    (head_id),
        .head_score (head_score)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        gid_next        = gid_reg;
        req_score_next  = req_score_reg;
        old_score_next  = old_score_reg;
        out_status_next = out_status_reg;
        out_group_next  = out_group_reg;
        out_score_next  = out_score_reg;
        out_last_next   = out_last_reg;
        emit            = 1'b0;
        ring_ctrl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    gid_next       = req.group_id;
                    req_score_next = req.new_score;
                    cnt_next       = '0;
                    state_next     = (req.action == ACT_WALK) ? ST_WALK : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                ring_ctrl.shift = 1'b1;
                if (head_id == IdW'(gid_reg))
                begin
                    old_score_next = head_score;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!gid_ok)
                begin
                    if (emit_ok)
                    begin
                        emit            = 1'b1;
                        out_status_next = ST_REJECT;
                        out_group_next  = gid_reg;
                        out_score_next  = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (req_score_reg > SCORE_MAX)
                begin
                    if (emit_ok)
                    begin
                        emit            = 1'b1;
                        out_status_next = ST_REJECT;
                        out_group_next  = gid_reg;
                        out_score_next  = old_score_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (REQ_SCORE_W'(old_score_reg) == req_score_reg)
                begin
                    if (emit_ok)
                    begin
                        emit            = 1'b1;
                        out_status_next = ST_SAME;
                        out_group_next  = gid_reg;
                        out_score_next  = old_score_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    ring_ctrl.start = 1'b1;
                    state_next      = ST_REBUILD;
                end
            end
            ST_REBUILD:
            begin
                ring_ctrl.shift     = 1'b1;
                ring_ctrl.rebuild   = 1'b1;
                ring_ctrl.tail_step = cnt_end;
                cnt_next            = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (emit_ok)
                begin
                    emit            = 1'b1;
                    out_status_next = ST_OK;
                    out_group_next  = gid_reg;
                    out_score_next  = SCORE_W'(req_score_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (emit_ok)
                begin
                    emit            = 1'b1;
                    ring_ctrl.shift = 1'b1;
                    out_status_next = ST_OK;
                    out_group_next  = ID_W'(head_id);
                    out_score_next  = head_score;
                    out_last_next   = cnt_end;
                    cnt_next        = cnt_reg + 1'b1;
                    if (cnt_end)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gid_reg        <= gid_next;
        req_score_reg  <= req_score_next;
        old_score_reg  <= old_score_next;
        out_status_reg <= out_status_next;
        out_group_reg  <= out_group_next;
        out_score_reg  <= out_score_next;
        out_last_reg   <= out_last_next;
    end

    `SOGL_ASSERT(a_busy_after_accept, clk, rst_n, req_fire |=> !req.ready, "taken while busy")
    `SOGL_NEVER(a_cnt_range, clk, rst_n, cnt_reg > IdW'(GROUPS - 1), "rank counter out of range")
    `SOGL_ASSERT(a_walk_ends_idle, clk, rst_n, walk_done |=> (state_reg == ST_IDLE), "walk overran")
    `SOGL_NEVER(a_status_code, clk, rst_n, out_valid_reg && status_bad, "undefined status")

endmodule

// File: dv/score_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Score list checker
// Watches the request and response channels of the score-ordered group list.
// It keeps its own copy of the rank order and the group scores, works out
// the beats that each accepted request must produce, and compares every
// accepted response beat field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module score_list_checker
    import sogl_pkg::*;
#(
    parameter int GROUPS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    sogl_req_if  req,
    sogl_rsp_if  rsp,
    output int   mismatches,
    output int   awaited
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     grp;
        logic [SCORE_W-1:0]  score;
        logic                fin;
    } rank_beat_t;

    rank_beat_t          pending_beats[$];
    logic [ID_W-1:0]     rank_tbl[GROUPS];
    logic [SCORE_W-1:0]  score_tbl[GROUPS];

    task automatic reposition_group(input logic [ID_W-1:0] g);
        logic [ID_W-1:0] others[GROUPS-1];
        int              n;
        int              ins;
        n = 0;
        for (int r = 0; r < GROUPS; r++)
        begin
            if (rank_tbl[r] != g)
            begin
                others[n] = rank_tbl[r];
                n++;
            end
        end
        ins = GROUPS - 1;
        for (int r = GROUPS - 2; r >= 0; r--)
        begin
            if (score_tbl[others[r]] < score_tbl[g])
                ins = r;
        end
        n = 0;
        for (int r = 0; r < GROUPS; r++)
        begin
            if (r == ins)
                rank_tbl[r] = g;
            else
            begin
                rank_tbl[r] = others[n];
                n++;
            end
        end
    endtask

    task automatic predict_request(input logic act, input logic [ID_W-1:0] g,
                                   input logic [REQ_SCORE_W-1:0] val);
        rank_beat_t b;
        if (act == ACT_WALK)
        begin
            for (int r = 0; r < GROUPS; r++)
            begin
                b.status = ST_OK;
                b.grp    = rank_tbl[r];
                b.score  = score_tbl[rank_tbl[r]];
                b.fin    = (r == GROUPS - 1);
                pending_beats.push_back(b);
            end
        end
        else
        begin
            b.grp = g;
            b.fin = 1'b1;
            if (int'(g) >= GROUPS)
            begin
                b.status = ST_REJECT;
                b.score  = '0;
            end
            else
            begin
                if (val > SCORE_MAX)
                    b.status = ST_REJECT;
                else if (REQ_SCORE_W'(score_tbl[g]) == val)
                    b.status = ST_SAME;
                else
                begin
                    b.status     = ST_OK;
                    score_tbl[g] = val[SCORE_W-1:0];
                    reposition_group(g);
                end
                b.score = score_tbl[g];
            end
            pending_beats.push_back(b);
        end
    endtask

    task automatic check_beat(input rank_beat_t got);
        rank_beat_t want;
        if (pending_beats.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected beat status=%0d group=%0d score=%0d last=%0b",
                         $realtime, got.status, got.grp, got.score, got.fin);
            mismatches++;
        end
        else
        begin
            want = pending_beats.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: beat mismatch expected status=%0d group=%0d score=%0d last=%0b",
                             $realtime, want.status, want.grp, want.score, want.fin);
                    $display("    got status=%0d group=%0d score=%0d last=%0b",
                             got.status, got.grp, got.score, got.fin);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GROUPS; r++)
            begin
                rank_tbl[r]  = ID_W'(r);
                score_tbl[r] = '0;
            end
            pending_beats.delete();
            mismatches = 0;
            awaited    = 0;
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_request(req.action, req.group_id, req.new_score);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_beat({rsp.status, rsp.out_group, rsp.out_score, rsp.last});
            awaited = pending_beats.size();
        end
    end

endmodule

// File: dv/score_ordered_group_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Score-ordered group list testbench
// Drives directed and then random set-score and walk requests into the block,
// with random gaps on the request side and random stalls on the response
// side, a long response hold-off and a drain pause. A checker beside the
// block predicts and compares every response beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module score_ordered_group_list_tb;
    import sogl_pkg::*;

    localparam int GROUPS       = 16;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited;
    bit   send_gaps_on;
    bit   hold_request;
    bit   hold_done;

    sogl_req_if req_ch();
    sogl_rsp_if rsp_ch();

    score_ordered_group_list #(.GROUPS(GROUPS)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    score_list_checker #(.GROUPS(GROUPS)) checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input logic act, input logic [ID_W-1:0] g,
                                input logic [REQ_SCORE_W-1:0] val);
        while (send_gaps_on && $urandom_range(0, 99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.group_id  <= g;
        req_ch.new_score <= val;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int cycle_no;
        rsp_ch.ready <= 1'b0;
        cycle_no = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (hold_request && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
                cycle_no  += HOLD_CYCLES;
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b1;
            end
            else if (cycle_no >= 3000 && cycle_no < 3600)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= 31);
        end
    end

    initial
    begin
        logic                   act;
        logic [ID_W-1:0]        g;
        logic [REQ_SCORE_W-1:0] val;
        int                     pick;

        send_gaps_on     = 1'b1;
        hold_request     = 1'b0;
        hold_done        = 1'b0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.action    <= ACT_SET;
        req_ch.group_id  <= '0;
        req_ch.new_score <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_WALK, 4'd0,  16'd0);
        send_request(ACT_SET,  4'd0,  16'd0);
        send_request(ACT_SET,  4'd15, 16'd1000);
        send_request(ACT_SET,  4'd0,  16'd1000);
        send_request(ACT_SET,  4'd7,  16'hFFFF);
        send_request(ACT_SET,  4'd7,  16'd1001);
        send_request(ACT_SET,  4'd7,  16'd1000);
        send_request(ACT_WALK, 4'd15, 16'hFFFF);
        send_request(ACT_SET,  4'd15, 16'd0);
        send_request(ACT_SET,  4'd3,  16'd500);
        send_request(ACT_SET,  4'd3,  16'd500);
        send_request(ACT_SET,  4'd3,  16'd1);
        send_request(ACT_SET,  4'd0,  16'd999);
        send_request(ACT_SET,  4'd10, 16'h0155);
        send_request(ACT_SET,  4'd5,  16'h02AA);
        send_request(ACT_SET,  4'd9,  16'h8000);
        send_request(ACT_WALK, 4'd10, 16'h5555);
        send_request(ACT_SET,  4'd12, 16'd1);
        send_request(ACT_SET,  4'd15, 16'd1000);
        send_request(ACT_SET,  4'd0,  16'd0);
        send_request(ACT_WALK, 4'd5,  16'hAAAA);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 60)
                hold_request = 1'b1;
            if (n == 150)
                drain_results();
            send_gaps_on = !(n >= 200 && n < 260);
            act  = ($urandom_range(0, 99) < 15) ? ACT_WALK : ACT_SET;
            g    = ID_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                val = REQ_SCORE_W'($urandom_range(0, 7));
            else if (pick < 65)
                val = REQ_SCORE_W'($urandom_range(0, 1000));
            else if (pick < 75)
                val = REQ_SCORE_W'($urandom_range(999, 1001));
            else if (pick < 90)
                val = REQ_SCORE_W'($urandom_range(1001, 65535));
            else
                val = REQ_SCORE_W'($urandom);
            send_request(act, g, val);
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (2 * GROUPS + 8) @(posedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
